FILE: rtl/core/dpy_pkg.sv
`timescale 1ns / 1ps

package dpy_pkg;

	localparam int D_W = 33;
	localparam int XY_W = 61;
	localparam int Z_W = 34;
	localparam int IDX_W = 5;
	localparam int ATAN_W = 31;
	localparam int GUARD_SH = 24;
	localparam int RND_W = Z_W - 8;
	localparam int PITCH_W = 24;
	localparam int YAW_W = 25;
	localparam int TAB_DEPTH = 32;

	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
	localparam logic signed [Z_W-1:0] DEG180_Q24 = 34'sd3019898880;
	localparam logic signed [Z_W-1:0] ROUND_HALF = 34'sd128;
	localparam logic signed [RND_W-1:0] DEG89_Q16 = 26'sd5832704;
	localparam logic signed [RND_W-1:0] DEG180_Q16 = 26'sd11796480;
	localparam logic signed [RND_W-1:0] DEG360_Q16 = 26'sd23592960;

	typedef struct packed {
		logic load;
		logic setup;
		logic emit_vert;
		logic iter;
		logic yaw_fin;
		logic mul_hi;
		logic pitch_fin;
		logic [IDX_W-1:0] idx;
	} dpy_cmd_t;

	function automatic logic [ATAN_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0: r = 31'd754974720;
			5'd1: r = 31'd445687602;
			5'd2: r = 31'd235489088;
			5'd3: r = 31'd119537938;
			5'd4: r = 31'd60000934;
			5'd5: r = 31'd30029717;
			5'd6: r = 31'd15018523;
			5'd7: r = 31'd7509720;
			5'd8: r = 31'd3754917;
			5'd9: r = 31'd1877466;
			5'd10: r = 31'd938734;
			5'd11: r = 31'd469367;
			5'd12: r = 31'd234684;
			5'd13: r = 31'd117342;
			5'd14: r = 31'd58671;
			5'd15: r = 31'd29335;
			5'd16: r = 31'd14668;
			5'd17: r = 31'd7334;
			5'd18: r = 31'd3667;
			5'd19: r = 31'd1833;
			5'd20: r = 31'd917;
			5'd21: r = 31'd458;
			5'd22: r = 31'd229;
			5'd23: r = 31'd115;
			5'd24: r = 31'd57;
			5'd25: r = 31'd29;
			5'd26: r = 31'd14;
			5'd27: r = 31'd7;
			5'd28: r = 31'd4;
			5'd29: r = 31'd2;
			5'd30: r = 31'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/dpy_ctrl.sv
`timescale 1ns / 1ps

module dpy_ctrl #(
	parameter int CORDIC_STEPS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic vertical,
	output logic busy,
	output dpy_pkg::dpy_cmd_t cmd
);
	import dpy_pkg::*;

	localparam int ITERS = (CORDIC_STEPS < TAB_DEPTH) ? CORDIC_STEPS : TAB_DEPTH;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ITERS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_YAW = 3'd2;
	localparam logic [2:0] S_YAWFIN = 3'd3;
	localparam logic [2:0] S_MULHI = 3'd4;
	localparam logic [2:0] S_PITCH = 3'd5;
	localparam logic [2:0] S_PITCHFIN = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				if (vertical) begin
					cmd.emit_vert = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.setup = 1'b1;
					state_d = S_YAW;
				end
			end
			S_YAW: begin
				cmd.iter = 1'b1;
				if (idx_q == LAST) begin
					idx_d = '0;
					state_d = S_YAWFIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_YAWFIN: begin
				cmd.yaw_fin = 1'b1;
				state_d = S_MULHI;
			end
			S_MULHI: begin
				cmd.mul_hi = 1'b1;
				state_d = S_PITCH;
			end
			S_PITCH: begin
				cmd.iter = 1'b1;
				if (idx_q == LAST) begin
					idx_d = '0;
					state_d = S_PITCHFIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_PITCHFIN: begin
				cmd.pitch_fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				idx_d = '0;
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (idx_q == '0))
		else $error("iteration counter not cleared while idle");

	a_yaw_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YAW && idx_q == LAST) |=> (state_q == S_YAWFIN))
		else $error("yaw pass did not end after the last iteration");

	a_setup_go: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SETUP && !vertical) |=> (state_q == S_YAW))
		else $error("setup did not start the yaw pass");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

endmodule

FILE: rtl/core/dpy_datapath.sv
`timescale 1ns / 1ps

module dpy_datapath (
	input logic clk,
	input logic arst_n,
	input dpy_pkg::dpy_cmd_t cmd,
	input logic signed [31:0] src_x,
	input logic signed [31:0] src_y,
	input logic signed [31:0] src_z,
	input logic signed [31:0] dst_x,
	input logic signed [31:0] dst_y,
	input logic signed [31:0] dst_z,
	output logic vertical,
	output logic signed [dpy_pkg::PITCH_W-1:0] pitch_deg,
	output logic signed [dpy_pkg::YAW_W-1:0] yaw_deg,
	output logic done
);
	import dpy_pkg::*;

	logic signed [D_W-1:0] dx_q;
	logic signed [D_W-1:0] dy_q;
	logic signed [D_W-1:0] dz_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [Z_W-1:0] base_q;
	logic [63:0] prod_q;
	logic signed [RND_W-1:0] yaw_pre_q;
	logic signed [YAW_W-1:0] yaw_wr_q;
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [YAW_W-1:0] yaw_q;
	logic done_q;

	logic signed [XY_W-1:0] dx_ext;
	logic signed [XY_W-1:0] dy_ext;
	logic signed [XY_W-1:0] dz_neg;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] atan_v;
	logic signed [Z_W-1:0] yaw_sum;
	logic signed [Z_W-1:0] pitch_sum;
	logic signed [RND_W-1:0] yaw_rnd;
	logic signed [RND_W-1:0] yaw_wrap;
	logic signed [RND_W-1:0] pitch_rnd;
	logic signed [RND_W-1:0] pitch_clamp;
	logic [XY_W-1:0] hi_prod;

	assign vertical = (dx_q == '0) && (dy_q == '0);

	assign dx_ext = {{(XY_W-D_W-GUARD_SH){dx_q[D_W-1]}}, dx_q, {GUARD_SH{1'b0}}};
	assign dy_ext = {{(XY_W-D_W-GUARD_SH){dy_q[D_W-1]}}, dy_q, {GUARD_SH{1'b0}}};
	assign dz_neg = -{{(XY_W-D_W-GUARD_SH){dz_q[D_W-1]}}, dz_q, {GUARD_SH{1'b0}}};

	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;
	assign atan_v = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q24(cmd.idx)});

	assign yaw_sum = z_q + base_q + ROUND_HALF;
	assign yaw_rnd = yaw_sum[Z_W-1:8];
	assign pitch_sum = z_q + ROUND_HALF;
	assign pitch_rnd = pitch_sum[Z_W-1:8];

	always_comb begin
		if (yaw_pre_q > DEG180_Q16) begin
			yaw_wrap = yaw_pre_q - DEG360_Q16;
		end else if (yaw_pre_q <= -DEG180_Q16) begin
			yaw_wrap = yaw_pre_q + DEG360_Q16;
		end else begin
			yaw_wrap = yaw_pre_q;
		end
	end

	always_comb begin
		if (pitch_rnd > DEG89_Q16) begin
			pitch_clamp = DEG89_Q16;
		end else if (pitch_rnd < -DEG89_Q16) begin
			pitch_clamp = -DEG89_Q16;
		end else begin
			pitch_clamp = pitch_rnd;
		end
	end

	assign hi_prod = {{(XY_W-(XY_W-32)){1'b0}}, x_q[XY_W-1:32]}
		* {{(XY_W-32){1'b0}}, INV_GAIN};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= D_W'(dst_x) - D_W'(src_x);
			dy_q <= D_W'(dst_y) - D_W'(src_y);
			dz_q <= D_W'(dst_z) - D_W'(src_z);
		end
		if (cmd.setup) begin
			z_q <= '0;
			if (dx_q[D_W-1]) begin
				x_q <= -dx_ext;
				y_q <= -dy_ext;
				base_q <= dy_q[D_W-1] ? -DEG180_Q24 : DEG180_Q24;
			end else begin
				x_q <= dx_ext;
				y_q <= dy_ext;
				base_q <= '0;
			end
		end else if (cmd.iter) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end else if (cmd.mul_hi) begin
			x_q <= $signed(hi_prod + {{(XY_W-32){1'b0}}, prod_q[63:32]});
			y_q <= dz_neg;
			z_q <= '0;
		end
		if (cmd.yaw_fin) begin
			prod_q <= 64'(x_q[31:0]) * 64'(INV_GAIN);
			yaw_pre_q <= yaw_rnd;
		end
		if (cmd.mul_hi) begin
			yaw_wr_q <= yaw_wrap[YAW_W-1:0];
		end
		if (cmd.emit_vert) begin
			yaw_q <= '0;
			pitch_q <= dz_q[D_W-1] || (dz_q == '0) ? DEG89_Q16[PITCH_W-1:0]
				: -DEG89_Q16[PITCH_W-1:0];
		end else if (cmd.pitch_fin) begin
			yaw_q <= yaw_wr_q;
			pitch_q <= pitch_clamp[PITCH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_vert || cmd.pitch_fin;
		end
	end

	assign pitch_deg = pitch_q;
	assign yaw_deg = yaw_q;
	assign done = done_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.emit_vert || cmd.pitch_fin))
		else $error("result word without a finishing step");

	a_pitch_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (RND_W'(pitch_q) <= DEG89_Q16 && RND_W'(pitch_q) >= -DEG89_Q16))
		else $error("pitch out of range");

	a_yaw_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (RND_W'(yaw_q) <= DEG180_Q16 && RND_W'(yaw_q) > -DEG180_Q16))
		else $error("yaw out of range");

endmodule

FILE: rtl/core/direction_to_pitch_yaw.sv
`timescale 1ns / 1ps

// Aim angles from a source point to a destination point, computed with two CORDIC
// vectoring passes on one shared iteration unit. A word is taken when start is high
// and busy is low. Busy then stays high through a setup step, the yaw iterations,
// the gain-correction multiply on the low and then the high half of the length, the
// pitch iterations and a final rounding step; each pass runs min(CORDIC_STEPS, 32)
// iterations. A direction with no horizontal component skips both passes. The result
// is shown for exactly one cycle with done high, in the first cycle after busy falls,
// and no new word is taken while busy is high. The result cannot be held off, so the
// receiver must take it in that cycle; start may be raised again in the same cycle.

module direction_to_pitch_yaw #(
	parameter int CORDIC_STEPS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] src_x,
	input logic signed [31:0] src_y,
	input logic signed [31:0] src_z,
	input logic signed [31:0] dst_x,
	input logic signed [31:0] dst_y,
	input logic signed [31:0] dst_z,
	output logic done,
	output logic signed [dpy_pkg::PITCH_W-1:0] pitch_deg,
	output logic signed [dpy_pkg::YAW_W-1:0] yaw_deg
);
	import dpy_pkg::*;

	dpy_cmd_t cmd;
	logic vertical;

	dpy_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.vertical(vertical),
		.busy(busy),
		.cmd(cmd)
	);

	dpy_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.src_x(src_x),
		.src_y(src_y),
		.src_z(src_z),
		.dst_x(dst_x),
		.dst_y(dst_y),
		.dst_z(dst_z),
		.vertical(vertical),
		.pitch_deg(pitch_deg),
		.yaw_deg(yaw_deg),
		.done(done)
	);

endmodule

FILE: bench/tb_direction_to_pitch_yaw.sv
`timescale 1ns / 1ps

module tb_direction_to_pitch_yaw;

	import dpy_pkg::PITCH_W;
	import dpy_pkg::YAW_W;

	localparam int STEPS = 24;
	localparam int SETTLE_CYCLES = 80;
	localparam longint ROUND_BIAS = 128;
	localparam longint HALF_TURN_Q24 = 64'sd3019898880;
	localparam longint LIMIT_Q16 = 64'sd5832704;
	localparam longint HALF_TURN_Q16 = 64'sd11796480;
	localparam longint FULL_TURN_Q16 = 64'sd23592960;
	localparam logic [63:0] RECIP_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
	localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] dst_x;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_z;
	} point_pair_t;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch;
		logic signed [YAW_W-1:0] yaw;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] src_x = '0;
	logic signed [31:0] src_y = '0;
	logic signed [31:0] src_z = '0;
	logic signed [31:0] dst_x = '0;
	logic signed [31:0] dst_y = '0;
	logic signed [31:0] dst_z = '0;
	logic done;
	logic signed [PITCH_W-1:0] pitch_deg;
	logic signed [YAW_W-1:0] yaw_deg;

	angles_t expected_angles[$];
	int mismatch_count = 0;

	// Arctangent of 2^-i in degrees, Q.24.
	longint arctan_q24[32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
		117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
		115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	direction_to_pitch_yaw #(
		.CORDIC_STEPS(STEPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_x(src_x),
		.src_y(src_y),
		.src_z(src_z),
		.dst_x(dst_x),
		.dst_y(dst_y),
		.dst_z(dst_z),
		.done(done),
		.pitch_deg(pitch_deg),
		.yaw_deg(yaw_deg)
	);

	always #10 clk = ~clk;

	// Rotates the vector onto the positive x axis and returns the swept angle in Q.24 degrees.
	function automatic longint rotate_to_axis(inout longint vx, inout longint vy);
		longint ang;
		longint sx;
		longint sy;
		ang = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				ang = ang + arctan_q24[i];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				ang = ang - arctan_q24[i];
			end
		end
		return ang;
	endfunction

	function automatic angles_t aim_angles(input point_pair_t w);
		angles_t a;
		longint dx;
		longint dy;
		longint dz;
		longint vx;
		longint vy;
		longint base;
		longint ang;
		longint yaw;
		longint pitch;
		logic [63:0] mag;
		logic [63:0] hi;
		logic [63:0] lo;
		dx = longint'(w.dst_x) - longint'(w.src_x);
		dy = longint'(w.dst_y) - longint'(w.src_y);
		dz = longint'(w.dst_z) - longint'(w.src_z);
		if (dx == 0 && dy == 0) begin
			yaw = 0;
			pitch = (dz > 0) ? -LIMIT_Q16 : LIMIT_Q16;
		end else begin
			vx = dx <<< 24;
			vy = dy <<< 24;
			base = 0;
			if (vx < 0) begin
				vx = -vx;
				vy = -vy;
				base = (dy >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
			end
			ang = rotate_to_axis(vx, vy);
			yaw = (ang + base + ROUND_BIAS) >>> 8;
			if (yaw > HALF_TURN_Q16)
				yaw = yaw - FULL_TURN_Q16;
			else if (yaw <= -HALF_TURN_Q16)
				yaw = yaw + FULL_TURN_Q16;
			// The horizontal length carries the CORDIC gain, which is taken out here.
			mag = vx;
			hi = mag >> 32;
			lo = {32'd0, mag[31:0]};
			vx = longint'(hi * RECIP_GAIN_Q32 + ((lo * RECIP_GAIN_Q32) >> 32));
			vy = (-dz) <<< 24;
			ang = rotate_to_axis(vx, vy);
			pitch = (ang + ROUND_BIAS) >>> 8;
			if (pitch > LIMIT_Q16)
				pitch = LIMIT_Q16;
			else if (pitch < -LIMIT_Q16)
				pitch = -LIMIT_Q16;
		end
		a.pitch = pitch[PITCH_W-1:0];
		a.yaw = yaw[YAW_W-1:0];
		return a;
	endfunction

	function automatic point_pair_t pair_of(input logic signed [31:0] sx, sy, sz, dx, dy, dz);
		point_pair_t w;
		w.src_x = sx;
		w.src_y = sy;
		w.src_z = sz;
		w.dst_x = dx;
		w.dst_y = dy;
		w.dst_z = dz;
		return w;
	endfunction

	function automatic logic signed [31:0] scaled_delta();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	function automatic logic signed [31:0] corner_value();
		case ($urandom_range(0, 4))
			0: return MIN32;
			1: return MAX32;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	task automatic send_word(input point_pair_t w, input int idle_pct);
		int gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		src_x <= w.src_x;
		src_y <= w.src_y;
		src_z <= w.src_z;
		dst_x <= w.dst_x;
		dst_y <= w.dst_y;
		dst_z <= w.dst_z;
		do @(posedge clk); while (busy);
		expected_angles.push_back(aim_angles(w));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_vertical();
		send_word(pair_of(0, 0, 0, 0, 0, 0), 22);
		send_word(pair_of(5, 5, 5, 5, 5, 6), 22);
		send_word(pair_of(5, 5, 5, 5, 5, 4), 22);
		send_word(pair_of(MIN32, MAX32, MIN32, MIN32, MAX32, MAX32), 22);
		send_word(pair_of(MAX32, MIN32, MAX32, MAX32, MIN32, MIN32), 22);
	endtask

	task automatic test_half_planes();
		send_word(pair_of(100, 0, 0, -100, 0, 0), 22);
		send_word(pair_of(0, 0, 0, -300, 200, 0), 22);
		send_word(pair_of(0, 0, 0, -300, -200, 50), 22);
		send_word(pair_of(0, 0, 0, 256, 0, 0), 22);
		send_word(pair_of(0, 0, 0, 0, 256, -256), 22);
		send_word(pair_of(0, 0, 0, 0, -256, 256), 22);
		send_word(pair_of(1, 0, 0, 0, -1, 0), 22);
		// Nearly opposite to the x axis, so the rounded yaw lands on the wrap point.
		send_word(pair_of(MAX32, 0, 0, MIN32, -1, 0), 22);
		send_word(pair_of(MAX32, 0, 0, MIN32, 1, 0), 22);
	endtask

	task automatic test_extremes();
		send_word(pair_of(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32), 22);
		send_word(pair_of(MAX32, MAX32, MAX32, MIN32, MIN32, MIN32), 22);
		send_word(pair_of(0, 0, MIN32, 1, 0, MAX32), 22);
		send_word(pair_of(0, 0, MAX32, 0, 1, MIN32), 22);
		send_word(pair_of(MIN32, MAX32, 0, MAX32, MIN32, 0), 22);
		send_word(pair_of(0, 0, 0, 1, 1, 1), 22);
		send_word(pair_of(-1, -1, -1, 0, 0, 0), 22);
		send_word(pair_of(MAX32, MAX32, 0, MAX32 - 1, MAX32, -1), 22);
	endtask

	task automatic test_random_directions(input int count, input int idle_pct);
		point_pair_t w;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			w = pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			if (pick >= 30 && pick < 60) begin
				w.dst_x = w.src_x + scaled_delta();
				w.dst_y = w.src_y + scaled_delta();
				w.dst_z = w.src_z + scaled_delta();
			end else if (pick >= 60 && pick < 70) begin
				w.dst_x = w.src_x;
				w.dst_y = w.src_y;
				if ($urandom_range(0, 3) == 0)
					w.dst_z = w.src_z;
			end else if (pick >= 70 && pick < 80) begin
				w.dst_x = w.src_x + scaled_delta();
				w.dst_y = w.src_y + scaled_delta();
				if ($urandom_range(0, 1) == 0)
					w.dst_x = w.src_x;
				else
					w.dst_y = w.src_y;
			end else if (pick >= 80 && pick < 90) begin
				w.dst_x = w.src_x + ($signed(scaled_delta()) >>> 16);
				w.dst_y = w.src_y + ($signed(scaled_delta()) >>> 16);
			end else if (pick >= 90) begin
				w = pair_of(corner_value(), corner_value(), corner_value(),
					corner_value(), corner_value(), corner_value());
			end
			send_word(w, idle_pct);
		end
	endtask

	always @(posedge clk) begin
		angles_t want;
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				note_failure($sformatf("unexpected word: pitch %0d yaw %0d",
					pitch_deg, yaw_deg));
			end else begin
				want = expected_angles.pop_front();
				if (pitch_deg !== want.pitch)
					note_failure($sformatf("pitch_deg mismatch: expected %0d actual %0d",
						want.pitch, pitch_deg));
				if (yaw_deg !== want.yaw)
					note_failure($sformatf("yaw_deg mismatch: expected %0d actual %0d",
						want.yaw, yaw_deg));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_vertical();
		test_half_planes();
		test_extremes();
		test_random_directions(480, 22);
		wait_idle();
		test_random_directions(480, 47);
		wait_idle();
		test_random_directions(490, 0);
		wait_idle();
		if (mismatch_count == 0 && expected_angles.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
